// ----- hdl/median3_moving_average_sensor_macros.svh -----
// assertion helpers for the filter rtl
`ifndef MEDIAN3_MOVING_AVERAGE_SENSOR_MACROS_SVH
`define MEDIAN3_MOVING_AVERAGE_SENSOR_MACROS_SVH

// same-cycle implication, checked out of reset
`define M3MA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define M3MA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/m3ma_pkg.sv -----
package m3ma_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int WINDOW      = 10;
  localparam int IN_W        = 12;
  localparam int LEVEL_W     = 16;
  localparam int GAIN_W      = 16;
  localparam int GAIN_FRAC   = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  // running sum holds WINDOW full-scale samples
  localparam int SUM_W       = SAMPLE_BITS + $clog2(WINDOW);

  // exact divide by WINDOW: floor(x * RECIP_M >> RECIP_SHIFT) for x < 2**SUM_W
  localparam int    RECIP_SHIFT = SUM_W + $clog2(WINDOW);
  localparam int    RECIP_W     = SUM_W + 1;
  localparam longint RECIP_NUM  = (longint'(1) << RECIP_SHIFT) + longint'(WINDOW) - 1;
  localparam logic [RECIP_W-1:0] RECIP_M = RECIP_W'(RECIP_NUM / WINDOW);

  localparam int PROD_W = SAMPLE_BITS + GAIN_W;

  typedef logic [IN_W-1:0]        raw_t;
  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [SUM_W-1:0]       sum_t;
  typedef logic [LEVEL_W-1:0]     level_t;
  typedef logic [GAIN_W-1:0]      gain_t;
  typedef logic [CFG_IDX_W-1:0]   cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0]  cfg_data_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FILTER_ENABLE = 2'd0,
    REG_GAIN_ENABLE   = 2'd1,
    REG_GAIN          = 2'd2
  } cfg_reg_t;

  localparam gain_t  GAIN_RESET = gain_t'(256);
  localparam level_t LEVEL_MAX  = '1;

endpackage

// ----- hdl/m3ma_in_if.sv -----
interface m3ma_in_if;
  import m3ma_pkg::*;

  logic valid;
  logic ready;
  raw_t sample_first;
  raw_t sample_second;
  raw_t sample_third;

  modport source (output valid, output sample_first, output sample_second,
                  output sample_third, input ready);
  modport sink   (input valid, input sample_first, input sample_second,
                  input sample_third, output ready);
endinterface

// ----- hdl/m3ma_out_if.sv -----
interface m3ma_out_if;
  import m3ma_pkg::*;

  logic   valid;
  logic   ready;
  level_t level;

  modport source (output valid, output level, input ready);
  modport sink   (input valid, input level, output ready);
endinterface

// ----- hdl/m3ma_window.sv -----
module m3ma_window (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  m3ma_pkg::sample_t s_first,
  input  m3ma_pkg::sample_t s_second,
  input  m3ma_pkg::sample_t s_third,
  output m3ma_pkg::sum_t    sum_new,
  output m3ma_pkg::sum_t    sum_cur
);
  import m3ma_pkg::*;

  sample_t taps_r [WINDOW];
  sum_t    sum_r;
  sum_t    sum_nxt;
  sample_t lo;
  sample_t hi;
  sample_t med;

  // median of three
  always_comb begin
    if (s_first > s_second) begin
      lo = s_second;
      hi = s_first;
    end else begin
      lo = s_first;
      hi = s_second;
    end
    if (s_third > hi) begin
      med = hi;
    end else if (s_third > lo) begin
      med = s_third;
    end else begin
      med = lo;
    end
  end

  // oldest tap leaves, newest median enters
  assign sum_nxt = sum_r - sum_t'(taps_r[0]) + sum_t'(med);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      for (int i = 0; i < WINDOW; i++) begin
        taps_r[i] <= '0;
      end
    end else if (push) begin
      sum_r <= sum_nxt;
      for (int i = 0; i < WINDOW - 1; i++) begin
        taps_r[i] <= taps_r[i+1];
      end
      taps_r[WINDOW-1] <= med;
    end
  end

  assign sum_new = sum_nxt;
  assign sum_cur = sum_r;

endmodule

// ----- hdl/median3_moving_average_sensor.sv -----
// median-of-three then moving-average sensor filter with output gain
//
// in_chan carries one beat per reading: three raw 12-bit conversions.
// out_chan carries one beat per reading: the 16-bit level.
// cfg_we/cfg_index/cfg_data write filter_enable (0), gain_enable (1) and
// gain (2, unsigned 8.8); other indexes are ignored. write only while idle.
//
// pipeline: a beat accepted on in_chan shows on out_chan after the
// median/window stage, divide-by-window stage and gain/saturate stage.
// throughput: one beat per cycle unless out_chan stalls, set by the
// running-sum register, which updates in the cycle a reading is accepted.
// when out_chan stalls the three stages fill up; in_chan.ready drops only
// once all three hold a reading, and rises again as soon as one moves on.
// reset (synchronous, rst_n low) clears the window and the running sum,
// empties the pipeline and loads filter on, gain off, gain 1.0. the level
// ramps up over the first WINDOW filtered readings as the zeros age out.
module median3_moving_average_sensor (
  input  logic                clk,
  input  logic                rst_n,
  m3ma_in_if.sink             in_chan,
  m3ma_out_if.source          out_chan,
  input  logic                cfg_we,
  input  m3ma_pkg::cfg_idx_t  cfg_index,
  input  m3ma_pkg::cfg_data_t cfg_data
);
  import m3ma_pkg::*;
  `include "median3_moving_average_sensor_macros.svh"

  // config registers
  logic  filter_enable_r;
  logic  gain_enable_r;
  gain_t gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_enable_r <= 1'b1;
      gain_enable_r   <= 1'b0;
      gain_r          <= GAIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FILTER_ENABLE: filter_enable_r <= cfg_data[0];
        REG_GAIN_ENABLE:   gain_enable_r   <= cfg_data[0];
        REG_GAIN:          gain_r          <= gain_t'(cfg_data);
        default: ;
      endcase
    end
  end

  // stage handshake: a stage moves when it is empty or the next one moves
  logic v1_r, v2_r, out_valid_r;
  logic rdy1, rdy2, rdy3;
  logic in_beat;

  assign rdy3    = !out_valid_r || out_chan.ready;
  assign rdy2    = !v2_r || rdy3;
  assign rdy1    = !v1_r || rdy2;
  assign in_beat = in_chan.valid && rdy1;

  assign in_chan.ready = rdy1;

  // stage 1: median and window update at accept (window only while filtering)
  sample_t s_first, s_second, s_third;
  sum_t    win_sum_new;
  sum_t    win_sum;
  sum_t    val1_r, val1_nxt;
  logic    filt1_r;

  // samples masked (or widened) to the working sample width
  assign s_first  = sample_t'(in_chan.sample_first);
  assign s_second = sample_t'(in_chan.sample_second);
  assign s_third  = sample_t'(in_chan.sample_third);

  m3ma_window u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_beat && filter_enable_r),
    .s_first  (s_first),
    .s_second (s_second),
    .s_third  (s_third),
    .sum_new  (win_sum_new),
    .sum_cur  (win_sum)
  );

  // bypass keeps the first sample, window untouched
  assign val1_nxt = filter_enable_r ? win_sum_new : sum_t'(s_first);

  // stage 2: mean by reciprocal multiply, or the bypass value passed on
  logic [SUM_W+RECIP_W-1:0] div_prod;
  sample_t                  val2_r, val2_nxt;

  assign div_prod = (SUM_W+RECIP_W)'(val1_r) * (SUM_W+RECIP_W)'(RECIP_M);
  assign val2_nxt = filt1_r ? sample_t'(div_prod >> RECIP_SHIFT) : sample_t'(val1_r);

  // stage 3: gain, drop fraction, saturate (pass-through while gain is off)
  logic [PROD_W-1:0] gain_prod;
  logic [PROD_W-1:0] gain_scaled;
  level_t            level_r, level_nxt;

  assign gain_prod   = PROD_W'(val2_r) * PROD_W'(gain_r);
  assign gain_scaled = gain_prod >> GAIN_FRAC;

  always_comb begin
    if (!gain_enable_r) begin
      level_nxt = level_t'(val2_r);
    end else if (gain_scaled > PROD_W'(LEVEL_MAX)) begin
      level_nxt = LEVEL_MAX;
    end else begin
      level_nxt = level_t'(gain_scaled);
    end
  end

  // pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_chan.valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        out_valid_r <= v2_r;
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (in_beat) begin
      val1_r  <= val1_nxt;
      filt1_r <= filter_enable_r;
    end
    if (v1_r && rdy2) begin
      val2_r <= val2_nxt;
    end
    if (v2_r && rdy3) begin
      level_r <= level_nxt;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.level = level_r;

  // checks
  `M3MA_ASSERT_NOW(a_full_when_blocked, clk, rst_n, !in_chan.ready,
                   v1_r && v2_r && out_valid_r, "input blocked with a free stage")
  `M3MA_ASSERT_NEXT(a_accept_fills_s1, clk, rst_n, in_beat, v1_r,
                    "accepted beat lost at stage one")
  `M3MA_ASSERT_NEXT(a_bypass_keeps_sum, clk, rst_n, in_beat && !filter_enable_r,
                    $stable(win_sum), "bypass beat moved the window")

endmodule

// ----- tb/m3ma_level_checker.sv -----
module m3ma_level_checker (
  input  logic                clk,
  input  logic                rst_n,
  m3ma_in_if                  in_mon,
  m3ma_out_if                 out_mon,
  input  logic                cfg_we,
  input  m3ma_pkg::cfg_idx_t  cfg_index,
  input  m3ma_pkg::cfg_data_t cfg_data,
  output int unsigned         fail_count,
  output int unsigned         pending
);
  import m3ma_pkg::*;

  // mirrored block state
  sample_t     medians [WINDOW];
  int unsigned median_total;
  logic        filter_on;
  logic        gain_on;
  gain_t       gain_reg;

  level_t      level_queue [$];
  int unsigned fails = 0;

  function automatic sample_t middle_of(sample_t a, sample_t b, sample_t c);
    if ((a >= b && a <= c) || (a <= b && a >= c)) return a;
    if ((b >= a && b <= c) || (b <= a && b >= c)) return b;
    return c;
  endfunction

  // shifts the window when filtering, scales the value when gain is on and clamps it
  function automatic level_t next_level(raw_t a, raw_t b, raw_t c);
    sample_t         mid;
    longint unsigned value;
    if (filter_on) begin
      mid = middle_of(sample_t'(a), sample_t'(b), sample_t'(c));
      median_total = median_total - medians[0];
      for (int i = 0; i < WINDOW - 1; i++) medians[i] = medians[i + 1];
      medians[WINDOW - 1] = mid;
      median_total = median_total + mid;
      value = median_total / WINDOW;
    end else begin
      value = sample_t'(a);
    end
    if (gain_on) value = (value * gain_reg) >> GAIN_FRAC;
    if (value > LEVEL_MAX) value = LEVEL_MAX;
    return level_t'(value);
  endfunction

  always @(posedge clk) begin
    level_t want;
    if (!rst_n) begin
      for (int i = 0; i < WINDOW; i++) medians[i] = '0;
      median_total = 0;
      filter_on    = 1'b1;
      gain_on      = 1'b0;
      gain_reg     = GAIN_RESET;
      level_queue.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (level_queue.size() == 0) begin
          $error("level: expected none, actual %0d", out_mon.level);
          fails++;
        end else begin
          want = level_queue.pop_front();
          if (out_mon.level !== want) begin
            $error("level: expected %0d, actual %0d", want, out_mon.level);
            fails++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_FILTER_ENABLE: filter_on = cfg_data[0];
          REG_GAIN_ENABLE:   gain_on   = cfg_data[0];
          REG_GAIN:          gain_reg  = gain_t'(cfg_data);
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        level_queue.push_back(next_level(in_mon.sample_first, in_mon.sample_second,
                                         in_mon.sample_third));
    end
    fail_count <= fails;
    pending    <= level_queue.size();
  end

endmodule

// ----- tb/median3_moving_average_sensor_tb.sv -----
module median3_moving_average_sensor_tb;
  import m3ma_pkg::*;

  // index with no register behind it, writes there must be dropped
  localparam cfg_idx_t    REG_OUT_OF_RANGE = cfg_idx_t'(3);
  localparam int          PHASES           = 8;
  localparam int          PHASE_BEATS      = 190;
  localparam int unsigned CYCLE_LIMIT      = 200000;
  localparam raw_t        FULL             = '1;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  cfg_idx_t    cfg_index;
  cfg_data_t   cfg_data;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycles = 0;
  // no idling on either side while set
  logic        quiet = 1'b0;

  m3ma_in_if  in_chan ();
  m3ma_out_if out_chan ();

  median3_moving_average_sensor i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  m3ma_level_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_chan),
    .out_mon    (out_chan),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // receiver: stalls about 18 beats in a hundred unless quiet
  always @(negedge clk) begin
    out_chan.ready <= quiet || ($urandom_range(0, 99) >= 18);
  end

  // one reading, called and left at a falling edge
  task automatic send_reading(input raw_t a, input raw_t b, input raw_t c);
    while (!quiet && $urandom_range(0, 99) < 18) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid         <= 1'b1;
    in_chan.sample_first  <= a;
    in_chan.sample_second <= b;
    in_chan.sample_third  <= c;
    do @(posedge clk); while (!in_chan.ready);
    @(negedge clk);
  endtask

  // register write, leaves cfg_we high for the caller to drop
  task automatic write_reg(input cfg_idx_t idx, input cfg_data_t value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
  endtask

  // hold the sender until every level has come back
  task automatic drain();
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    raw_t        a, b, c;
    int unsigned pick;
    logic        filt;
    logic        gain_en;
    cfg_data_t   gain_val;

    // every input known from time zero
    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_index             = REG_FILTER_ENABLE;
    cfg_data              = '0;
    in_chan.valid         = 1'b0;
    in_chan.sample_first  = '0;
    in_chan.sample_second = '0;
    in_chan.sample_third  = '0;
    out_chan.ready        = 1'b0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: filter on, gain off; fresh window ramps up from zeros
    send_reading(FULL, FULL, FULL);    // equal samples
    send_reading('0, FULL, 12'd2048);  // median in every position
    send_reading(FULL, '0, 12'd2048);
    send_reading(12'd2048, '0, FULL);
    send_reading('0, 12'd2048, FULL);
    send_reading(FULL, 12'd2048, '0);
    send_reading(12'd2048, FULL, '0);
    send_reading('0, '0, '0);
    send_reading(FULL, '0, '0);
    send_reading('0, FULL, FULL);
    in_chan.valid <= 1'b0;
    drain();

    // stray index write, then full-scale gain so the product saturates
    write_reg(REG_OUT_OF_RANGE, '1);
    write_reg(REG_GAIN, '1);
    write_reg(REG_GAIN_ENABLE, cfg_data_t'(1));
    cfg_we <= 1'b0;
    send_reading(FULL, FULL, FULL);
    in_chan.valid <= 1'b0;
    drain();

    // gain applies to the bypass value too
    write_reg(REG_FILTER_ENABLE, cfg_data_t'(0));
    cfg_we <= 1'b0;
    send_reading(FULL, '0, '0);
    send_reading(12'd1, FULL, FULL);
    in_chan.valid <= 1'b0;
    drain();

    // zero gain
    write_reg(REG_GAIN, '0);
    cfg_we <= 1'b0;
    send_reading(FULL, 12'd1, 12'd2);
    in_chan.valid <= 1'b0;
    drain();

    // gain off: the zero gain must be ignored
    write_reg(REG_GAIN_ENABLE, cfg_data_t'(0));
    cfg_we <= 1'b0;
    send_reading(FULL, 12'd1, 12'd2);
    send_reading('0, FULL, FULL);
    in_chan.valid <= 1'b0;
    drain();

    // random phases, extremes of the settings first
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin filt = 1'b1; gain_en = 1'b0; gain_val = GAIN_RESET; end
        1: begin filt = 1'b0; gain_en = 1'b0; gain_val = cfg_data_t'($urandom); end
        2: begin filt = 1'b1; gain_en = 1'b1; gain_val = '1; end
        3: begin filt = 1'b1; gain_en = 1'b1; gain_val = '0; end
        4: begin filt = 1'b0; gain_en = 1'b1; gain_val = '1; end
        5: begin filt = 1'b0; gain_en = 1'b1; gain_val = GAIN_RESET; end
        default: begin
          filt     = 1'($urandom_range(0, 1));
          gain_en  = 1'($urandom_range(0, 1));
          // half the time near unity so the level stays off the rail
          gain_val = $urandom_range(0, 1) ? cfg_data_t'($urandom_range(128, 512))
                                          : cfg_data_t'($urandom);
        end
      endcase
      write_reg(REG_FILTER_ENABLE, cfg_data_t'(filt));
      write_reg(REG_GAIN_ENABLE, cfg_data_t'(gain_en));
      write_reg(REG_GAIN, gain_val);
      cfg_we <= 1'b0;
      // long stretch with back-to-back beats on both sides
      quiet = (p == 2);

      for (int n = 0; n < PHASE_BEATS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          a = raw_t'($urandom);
          b = raw_t'($urandom);
          c = raw_t'($urandom);
        end else if (pick < 70) begin
          // equal samples, sometimes two of three
          a = raw_t'($urandom);
          b = a;
          c = $urandom_range(0, 1) ? a : raw_t'($urandom);
        end else if (pick < 85) begin
          // rail values mixed with a random one
          a = $urandom_range(0, 1) ? FULL : '0;
          b = $urandom_range(0, 1) ? FULL : '0;
          c = raw_t'($urandom);
        end else begin
          // close together, as a quiet sensor gives
          a = raw_t'($urandom_range(8, 4087));
          b = a + raw_t'($urandom_range(0, 8)) - raw_t'(4);
          c = a + raw_t'($urandom_range(0, 8)) - raw_t'(4);
        end
        send_reading(a, b, c);
      end
      in_chan.valid <= 1'b0;
      quiet = 1'b0;
      drain();
    end

    // let any stray beat surface before the verdict
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
